[src/sitda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants
// Character codes, digit counts and control types for the signed integer to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW    = NumDigits * DigitW;
  localparam int unsigned CharW   = 7;
  localparam int unsigned CountW  = 5;
  localparam int unsigned RemW    = 4;

  localparam logic [CharW-1:0]  CharZero  = 7'd48;
  localparam logic [CharW-1:0]  CharMinus = 7'd45;
  localparam logic [CountW-1:0] LastShift = 5'd31;
  localparam logic [RemW-1:0]   RemFull   = 4'd10;
  localparam logic [RemW-1:0]   RemOne    = 4'd1;

  typedef enum logic [1:0] {
    StIdle,
    StSkip,
    StMinus,
    StEmit
  } sitda_state_e;

  typedef struct packed {
    logic done;
    logic neg;
  } sitda_conv_t;

endpackage

[src/signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
//
//   Channel   Direction  Handshake                 Payload
//   input     in         start && !busy            value_i
//   result    out        valid_o, one cycle each   char_code_o, last_o
//
// An item passes in sequence through the bit-serial BCD shifter, the load
// into the character sequencer and the leading zero scan, and then takes one
// cycle per character, a minus sign first when the value is negative.
// Characters of one item appear on consecutive cycles. The receiver cannot
// stall; busy stays high until the last character is registered.
// Reset is asynchronous and active low and returns the block to idle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii import sitda_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     busy,
  output logic                     valid_o,
  output logic [CharW-1:0]         char_code_o,
  output logic                     last_o
);

  logic            load;
  logic            conv_busy;
  logic            emit_busy;
  sitda_conv_t     conv;
  logic [BcdW-1:0] bcd;

  assign busy = conv_busy | emit_busy;
  assign load = start & ~busy;

  sitda_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .value_i (value_i),
    .busy_o  (conv_busy),
    .conv_o  (conv),
    .bcd_o   (bcd)
  );

  sitda_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .conv_i  (conv),
    .bcd_i   (bcd),
    .busy_o  (emit_busy),
    .valid_o (valid_o),
    .char_o  (char_code_o),
    .last_o  (last_o)
  );

endmodule

[src/sitda_dabble.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_dabble: bit-serial binary to BCD converter
// Shifts the magnitude in one bit per cycle and applies add-3 correction to
// each BCD digit, finishing after the last shift with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module sitda_dabble import sitda_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [ValueW-1:0] value_i,
  output logic              busy_o,
  output sitda_conv_t       conv_o,
  output logic [BcdW-1:0]   bcd_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [ValueW-1:0] bin_q;
  logic [BcdW-1:0]   bcd_q;
  logic              neg_q;
  logic [BcdW-1:0]   bcd_adj;

  function automatic logic [BcdW-1:0] add3(input logic [BcdW-1:0] bcd);
    logic [BcdW-1:0] res;
    logic [DigitW-1:0] dig;
    res = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      dig = bcd[i*DigitW +: DigitW];
      if (dig >= 4'd5) begin
        res[i*DigitW +: DigitW] = dig + 4'd3;
      end
    end
    return res;
  endfunction

  assign bcd_adj = add3(bcd_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (load_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == LastShift) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bin_q <= value_i[ValueW-1] ? (~value_i + 32'd1) : value_i;
      bcd_q <= '0;
      neg_q <= value_i[ValueW-1];
    end else if (busy_q) begin
      bin_q <= {bin_q[ValueW-2:0], 1'b0};
      bcd_q <= {bcd_adj[BcdW-2:0], bin_q[ValueW-1]};
    end
  end

  assign busy_o      = busy_q | done_q;
  assign conv_o.done = done_q;
  assign conv_o.neg  = neg_q;
  assign bcd_o       = bcd_q;

endmodule

[src/sitda_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_emit: character sequencer
// Shifts the BCD digits out one digit per cycle, skips leading zeros, puts
// the minus sign in front and drives the registered character outputs.
// ----------------------------------------------------------------------------
module sitda_emit import sitda_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sitda_conv_t      conv_i,
  input  logic [BcdW-1:0]  bcd_i,
  output logic             busy_o,
  output logic             valid_o,
  output logic [CharW-1:0] char_o,
  output logic             last_o
);

  sitda_state_e     state_q, state_d;
  logic [BcdW-1:0]  digits_q, digits_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic             neg_q, neg_d;
  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic [DigitW-1:0] top;

  assign top = digits_q[BcdW-1 -: DigitW];

  always_comb begin
    state_d  = state_q;
    digits_d = digits_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    valid_d  = 1'b0;
    char_d   = char_q;
    last_d   = last_q;
    unique case (state_q)
      StIdle: begin
        if (conv_i.done) begin
          digits_d = bcd_i;
          neg_d    = conv_i.neg;
          rem_d    = RemFull;
          state_d  = StSkip;
        end
      end
      StSkip: begin
        if (top == 4'd0 && rem_q != RemOne) begin
          digits_d = {digits_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          rem_d    = rem_q - 4'd1;
        end else if (neg_q) begin
          state_d = StMinus;
        end else begin
          state_d = StEmit;
        end
      end
      StMinus: begin
        valid_d = 1'b1;
        char_d  = CharMinus;
        last_d  = 1'b0;
        state_d = StEmit;
      end
      StEmit: begin
        valid_d  = 1'b1;
        char_d   = CharZero + {3'b000, top};
        last_d   = (rem_q == RemOne);
        digits_d = {digits_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
        rem_d    = rem_q - 4'd1;
        if (rem_q == RemOne) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
    char_q   <= char_d;
    last_q   <= last_d;
  end

  assign busy_o  = (state_q != StIdle);
  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

endmodule

[src/sitda_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_checker: port-level assertions
// Checks character codes, framing of the text and the busy handshake as seen
// on the top level's ports.
// ----------------------------------------------------------------------------
module sitda_checker import sitda_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             valid_o,
  input logic [CharW-1:0] char_code_o,
  input logic             last_o
);

  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (char_code_o == CharMinus ||
                 (char_code_o >= CharZero && char_code_o <= CharZero + 7'd9)))
    else $error("Invalid character code on the result port.");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && char_code_o == CharMinus) |-> !last_o)
    else $error("Minus sign flagged as the last character.");

  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o)
    else $error("Gap inside the text of one number.");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |=> !valid_o)
    else $error("Character transfer directly after the last character.");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Busy not raised after an input transfer.");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .valid_o     (valid_o),
  .char_code_o (char_code_o),
  .last_o      (last_o)
);

[test/sitda_char_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_char_checker: character stream checker for the decimal ASCII converter
// Watches the input and result channels. Every accepted value is turned into
// its expected decimal text, and every character strobe is compared with the
// oldest expected character, code and last flag both.
// ----------------------------------------------------------------------------
module sitda_char_checker import sitda_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [ValueW-1:0]        value_i,
  input  logic                     valid_i,
  input  logic [CharW-1:0]         char_code_i,
  input  logic                     last_i,
  output int unsigned              err_cnt_o,
  output int unsigned              pending_o
);

  localparam int unsigned Radix     = 10;
  localparam int unsigned MaxReport = 10;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } ascii_char_t;

  ascii_char_t text_q [$];
  int unsigned err_cnt = 0;

  assign err_cnt_o = err_cnt;
  assign pending_o = text_q.size();

  function automatic void push_text(input logic [ValueW-1:0] raw);
    logic [ValueW-1:0] mag;
    logic [DigitW-1:0] digs [NumDigits];
    int                nd;
    ascii_char_t       ch;
    mag = raw[ValueW-1] ? (~raw + 1'b1) : raw;
    nd  = 0;
    do begin
      digs[nd] = DigitW'(mag % Radix);
      nd++;
      mag = mag / Radix;
    end while (mag != 0 && nd < NumDigits);
    if (raw[ValueW-1]) begin
      ch.code = CharMinus;
      ch.last = 1'b0;
      text_q.push_back(ch);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      ch.code = CharZero + CharW'(digs[k]);
      ch.last = (k == 0);
      text_q.push_back(ch);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ascii_char_t want;
    if (!rst_ni) begin
      text_q.delete();
    end else begin
      if (start_i && !busy_i) begin
        push_text(value_i);
      end
      if (valid_i) begin
        if (text_q.size() == 0) begin
          if (err_cnt < MaxReport) begin
            $display("%0t: unexpected character %0d last %0b", $realtime, char_code_i,
                     last_i);
          end
          err_cnt++;
        end else begin
          want = text_q.pop_front();
          if (want.code !== char_code_i || want.last !== last_i) begin
            if (err_cnt < MaxReport) begin
              $display("%0t: mismatch, expected char %0d last %0b, got char %0d last %0b",
                       $realtime, want.code, want.last, char_code_i, last_i);
            end
            err_cnt++;
          end
        end
      end
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the signed integer to decimal ASCII converter
// Sends directed corner values (zero, one digit, powers of ten, the largest
// and most negative integers) and then random values of every digit count
// and sign, in bursts with random gaps. A checker beside the block predicts
// the character stream and counts mismatches; the top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import sitda_pkg::*;

  localparam int unsigned NumRandom = 87;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start  = 1'b0;
  logic [ValueW-1:0] value  = '0;
  logic              busy;
  logic              valid;
  logic [CharW-1:0]  char_code;
  logic              last;
  int unsigned       err_cnt;
  int unsigned       pending;

  logic [ValueW-1:0] corner_vals [$];
  int unsigned       pow10 [NumDigits];

  signed_int_to_decimal_ascii u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .value_i    (value),
    .busy       (busy),
    .valid_o    (valid),
    .char_code_o(char_code),
    .last_o     (last)
  );

  sitda_char_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .value_i    (value),
    .valid_i    (valid),
    .char_code_i(char_code),
    .last_i     (last),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  task automatic send_value(input logic [ValueW-1:0] v);
    start <= 1'b1;
    value <= v;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [ValueW-1:0] rand_value();
    logic [ValueW-1:0] v;
    int unsigned       nd;
    int unsigned       lo;
    int unsigned       hi;
    case ($urandom_range(0, 5))
      1: v = $urandom_range(0, 20);
      2: begin
        nd = $urandom_range(1, NumDigits);
        lo = (nd == 1) ? 0 : pow10[nd-1];
        hi = (nd == NumDigits) ? 32'h7FFF_FFFF : pow10[nd] - 1;
        v  = $urandom_range(hi, lo);
      end
      3: v = pow10[$urandom_range(0, NumDigits - 1)] + $urandom_range(0, 2) - 1;
      4: begin
        if ($urandom_range(0, 1)) v = 32'h8000_0000 + $urandom_range(0, 3);
        else                      v = 32'h7FFF_FFFF - $urandom_range(0, 3);
        return v;
      end
      default: return $urandom;
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    pow10[0] = 1;
    for (int i = 1; i < NumDigits; i++) pow10[i] = pow10[i-1] * 10;
    corner_vals = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
                    32'sd100, -32'sd100, 32'sd999999999, 32'sd1000000000,
                    -32'sd999999999, -32'sd1000000000, 32'sd2147483647,
                    32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'sd123456789, -32'sd123456789, 32'sd7, -32'sd7};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_vals[i]) begin
      send_value(corner_vals[i]);
      if (i % 3 == 2) begin
        start <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
      end
    end

    burst_left = 0;
    for (int n = 0; n < NumRandom; n++) begin
      send_value(rand_value());
      if (n >= 40 && n < 70) continue;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60) : $urandom_range(0, 12);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
    start <= 1'b0;

    while (pending != 0 || busy) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sitda_pkg.sv
src/sitda_dabble.sv
src/sitda_emit.sv
src/signed_int_to_decimal_ascii.sv
src/sitda_checker.sv
test/sitda_char_checker.sv
test/tb.sv
